// File: rtl/mqsd_pkg.sv
`default_nettype none
package mqsd_pkg;

  // Fixed field widths of the command and result transactions
  localparam int unsigned REQ_W    = 64;
  localparam int unsigned QSEL_W   = 3;
  localparam int unsigned ACTCFG_W = 4;
  localparam int unsigned LEN_W    = 5;

  // Operation codes
  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_INACTIVE = 2'd3
  } status_t;

  localparam logic [ACTCFG_W-1:0] ACTIVE_RESET = 4'd8;

endpackage
`default_nettype wire

// File: rtl/mqsd_ram.sv
`default_nettype none
module mqsd_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write on enable, register the read word every cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// File: rtl/mqsd_shortest.sv
`default_nettype none
module mqsd_shortest #(
  parameter int unsigned NUM_QUEUES = 8,
  parameter int unsigned CNT_W      = 5,
  parameter int unsigned QI_W       = 3,
  parameter int unsigned ACT_W      = 4
) (
  input  wire logic [NUM_QUEUES-1:0][CNT_W-1:0] counts,
  input  wire logic [ACT_W-1:0]                 act,
  output logic      [QI_W-1:0]                  best_idx,
  output logic      [CNT_W-1:0]                 best_len
);

  localparam int unsigned LEAVES = 1 << QI_W;
  localparam int unsigned KEY_W  = CNT_W + 1;

  logic [KEY_W-1:0] key  [2*LEAVES];
  logic [QI_W-1:0]  nidx [2*LEAVES];

  // Pairwise minimum tree; the left child holds the lower index and wins ties
  always_comb begin
    key[0]  = '0;
    nidx[0] = '0;
    for (int i = 0; i < LEAVES; i++) begin
      key[LEAVES+i]  = {1'b1, {CNT_W{1'b0}}};
      nidx[LEAVES+i] = QI_W'(i);
    end
    for (int i = 0; i < NUM_QUEUES; i++) begin
      if (ACT_W'(i) < act) begin
        key[LEAVES+i] = {1'b0, counts[i]};
      end
    end
    for (int n = LEAVES - 1; n >= 1; n--) begin
      if (key[2*n+1] < key[2*n]) begin
        key[n]  = key[2*n+1];
        nidx[n] = nidx[2*n+1];
      end else begin
        key[n]  = key[2*n];
        nidx[n] = nidx[2*n];
      end
    end
    best_idx = nidx[1];
    best_len = key[1][CNT_W-1:0];
  end

endmodule
`default_nettype wire

// File: rtl/multi_queue_shortest_dispatch.sv
`default_nettype none
// Bank of NUM_QUEUES bounded ring FIFOs of 64-bit request words with a
// join-shortest-queue report.
// Command channel: a transaction is taken at a clock edge with start high
// and busy low. in_req_type selects enqueue of in_request_word or dequeue
// of the head of queue in_queue_index.
// Result channel: out_valid is high for exactly one cycle with the status,
// the dequeued word, the addressed queue's length and the lowest-index
// shortest active queue, all taken after the operation. The receiver
// cannot stall; each result is presented once.
// Sequence: commands are taken one at a time. In the accept cycle the
// word store (one single-port RAM) is written or read and the head and
// count registers update; in the following cycle busy is high, the RAM
// read word arrives and the shortest-queue tree runs over the counts. The
// result shows in the cycle after that, in which a new command is taken.
// Configuration: cfg_active_queues is written when cfg_valid is high
// (cfg_ready is always high); write it only while no command is in flight.
// Reset (synchronous, rst_n low) empties every queue, zeroes the heads and
// sets eight active queues. Store contents need no clearing.
module multi_queue_shortest_dispatch
  import mqsd_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = 8,
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_req_type,
  input  wire logic [mqsd_pkg::QSEL_W-1:0]   in_queue_index,
  input  wire logic [mqsd_pkg::REQ_W-1:0]    in_request_word,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mqsd_pkg::ACTCFG_W-1:0] cfg_active_queues,
  output logic                               out_valid,
  output logic [1:0]                         out_status,
  output logic [mqsd_pkg::REQ_W-1:0]         out_request,
  output logic [mqsd_pkg::LEN_W-1:0]         out_queue_length,
  output logic [mqsd_pkg::QSEL_W-1:0]        out_shortest_index,
  output logic [mqsd_pkg::LEN_W-1:0]         out_shortest_length
);

  localparam int unsigned QI_W    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned NQ_W    = $clog2(NUM_QUEUES + 1);
  localparam int unsigned ACT_W   = (NQ_W > ACTCFG_W) ? NQ_W : ACTCFG_W;
  localparam int unsigned QX_W    = (QI_W > QSEL_W) ? QI_W : QSEL_W;
  localparam int unsigned ADDR_W  = QI_W + PTR_W;
  localparam int unsigned RAM_DEP = 1 << ADDR_W;

  logic [ACTCFG_W-1:0] active_r;
  logic [PTR_W-1:0]    head_r [NUM_QUEUES];
  logic [NUM_QUEUES-1:0][CNT_W-1:0] cnt_r;

  logic                phase_r;
  logic [QI_W-1:0]     q_r;
  logic                inactive_r;
  logic                deq_ok_r;
  status_t             status_r;

  logic                out_valid_r;
  status_t             out_status_r;
  logic [REQ_W-1:0]    out_request_r;
  logic [LEN_W-1:0]    out_qlen_r;
  logic [QSEL_W-1:0]   out_sidx_r;
  logic [LEN_W-1:0]    out_slen_r;

  logic                accept;
  logic [ACT_W-1:0]    act_eff;
  logic [QX_W-1:0]     q_ext;
  logic [QI_W-1:0]     q_idx;
  logic                q_inactive;
  logic [CNT_W-1:0]    cnt_cur;
  logic [PTR_W-1:0]    head_cur;
  logic [PTR_W:0]      tail_sum;
  logic [PTR_W-1:0]    tail_slot;
  logic [PTR_W-1:0]    head_inc;
  logic                is_full;
  logic                is_empty;
  logic                enq_ok;
  logic                deq_ok;
  status_t             status_nxt;
  logic                ram_we;
  logic [ADDR_W-1:0]   ram_addr;
  logic [REQ_W-1:0]    ram_rdata;
  logic [QI_W-1:0]     best_idx;
  logic [CNT_W-1:0]    best_len;
  logic [CNT_W-1:0]    qlen_cur;

  assign accept    = start & ~phase_r;
  assign busy      = phase_r;
  assign cfg_ready = 1'b1;

  // Clamp the active count into one to NUM_QUEUES
  always_comb begin
    if (active_r == '0) begin
      act_eff = ACT_W'(1);
    end else if (ACT_W'(active_r) > ACT_W'(NUM_QUEUES)) begin
      act_eff = ACT_W'(NUM_QUEUES);
    end else begin
      act_eff = ACT_W'(active_r);
    end
  end

  // Decode the command against the addressed queue's head and count
  always_comb begin
    q_ext      = QX_W'(in_queue_index);
    q_idx      = q_ext[QI_W-1:0];
    q_inactive = !(ACT_W'(in_queue_index) < act_eff);
    cnt_cur    = cnt_r[q_idx];
    head_cur   = head_r[q_idx];
    tail_sum   = (PTR_W+1)'(head_cur) + (PTR_W+1)'(cnt_cur);
    if (tail_sum >= (PTR_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (PTR_W+1)'(QUEUE_DEPTH);
    end
    tail_slot  = tail_sum[PTR_W-1:0];
    head_inc   = (head_cur == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_cur + PTR_W'(1);
    is_full    = (cnt_cur == CNT_W'(QUEUE_DEPTH));
    is_empty   = (cnt_cur == '0);
    enq_ok     = 1'b0;
    deq_ok     = 1'b0;
    status_nxt = ST_OK;
    if (q_inactive) begin
      status_nxt = ST_INACTIVE;
    end else if (in_req_type == OP_ENQ) begin
      if (is_full) begin
        status_nxt = ST_FULL;
      end else begin
        enq_ok = 1'b1;
      end
    end else begin
      if (is_empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        deq_ok = 1'b1;
      end
    end
    ram_we   = accept & enq_ok;
    ram_addr = enq_ok ? {q_idx, tail_slot} : {q_idx, head_cur};
  end

  mqsd_ram #(
    .WIDTH (REQ_W),
    .DEPTH (RAM_DEP)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (in_request_word),
    .rdata (ram_rdata)
  );

  mqsd_shortest #(
    .NUM_QUEUES (NUM_QUEUES),
    .CNT_W      (CNT_W),
    .QI_W       (QI_W),
    .ACT_W      (ACT_W)
  ) u_shortest (
    .counts   (cnt_r),
    .act      (act_eff),
    .best_idx (best_idx),
    .best_len (best_len)
  );

  assign qlen_cur = inactive_r ? '0 : cnt_r[q_r];

  // Hold the register, heads and counts; advance the command sequence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= ACTIVE_RESET;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head_r[i] <= '0;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        active_r <= cfg_active_queues;
      end
      phase_r     <= accept;
      out_valid_r <= phase_r;
      if (accept && enq_ok) begin
        cnt_r[q_idx] <= cnt_cur + CNT_W'(1);
      end
      if (accept && deq_ok) begin
        cnt_r[q_idx]  <= cnt_cur - CNT_W'(1);
        head_r[q_idx] <= head_inc;
      end
    end
  end

  // Carry the transaction's decode to the result cycle and register the result
  always_ff @(posedge clk) begin
    if (accept) begin
      q_r        <= q_idx;
      inactive_r <= q_inactive;
      deq_ok_r   <= deq_ok;
      status_r   <= status_nxt;
    end
    if (phase_r) begin
      out_status_r  <= status_r;
      out_request_r <= deq_ok_r ? ram_rdata : '0;
      out_qlen_r    <= LEN_W'(qlen_cur);
      out_sidx_r    <= QSEL_W'(best_idx);
      out_slen_r    <= LEN_W'(best_len);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_request         = out_request_r;
  assign out_queue_length    = out_qlen_r;
  assign out_shortest_index  = out_sidx_r;
  assign out_shortest_length = out_slen_r;

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

localparam int unsigned BANK_QUEUES = 8;
localparam int unsigned BANK_DEPTH  = 16;

typedef struct packed {
  mqsd_pkg::status_t status;
  logic [63:0]       request;
  logic [4:0]        qlen;
  logic [2:0]        sidx;
  logic [4:0]        slen;
} dispatch_result_t;

// Queue bank predictor with the store of results still to arrive
class queue_bank_model;
  logic [63:0]      words [BANK_QUEUES][BANK_DEPTH];
  logic [3:0]       heads [BANK_QUEUES];
  logic [4:0]       counts [BANK_QUEUES];
  logic [3:0]       active_setting;
  dispatch_result_t pending_results[$];
  int unsigned      failures;

  function new();
    foreach (heads[i]) begin
      heads[i]  = '0;
      counts[i] = '0;
      foreach (words[i][j]) words[i][j] = '0;
    end
    active_setting = mqsd_pkg::ACTIVE_RESET;
    failures = 0;
  endfunction

  function void set_active(logic [3:0] value);
    active_setting = value;
  endfunction

  // Clamp the register to the range of queues that exist
  function int unsigned in_use();
    int unsigned n;
    n = active_setting;
    if (n == 0) n = 1;
    if (n > BANK_QUEUES) n = BANK_QUEUES;
    return n;
  endfunction

  function void fail(string msg);
    failures++;
    if (failures <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Apply one command and queue the result it must produce
  function void note_command(mqsd_pkg::op_t op, logic [2:0] q, logic [63:0] word);
    dispatch_result_t r;
    logic [3:0]       slot;
    int unsigned      act;
    int unsigned      best;
    act = in_use();
    r = '0;
    r.status = mqsd_pkg::ST_OK;
    if (q >= act) begin
      r.status = mqsd_pkg::ST_INACTIVE;
    end else if (op == mqsd_pkg::OP_ENQ) begin
      if (counts[q] >= BANK_DEPTH) begin
        r.status = mqsd_pkg::ST_FULL;
      end else begin
        slot = heads[q] + counts[q][3:0];
        words[q][slot] = word;
        counts[q] = counts[q] + 5'd1;
      end
      r.qlen = counts[q];
    end else begin
      if (counts[q] == 0) begin
        r.status = mqsd_pkg::ST_EMPTY;
      end else begin
        r.request = words[q][heads[q]];
        heads[q] = heads[q] + 4'd1;
        counts[q] = counts[q] - 5'd1;
      end
      r.qlen = counts[q];
    end
    // Lowest index wins among equal lengths
    best = 0;
    for (int unsigned i = 1; i < act; i++) begin
      if (counts[i] < counts[best]) best = i;
    end
    r.sidx = best[2:0];
    r.slen = counts[best];
    pending_results.push_back(r);
  endfunction

  function void check_result(dispatch_result_t got);
    dispatch_result_t want;
    if (pending_results.size() == 0) begin
      fail("result with no transaction outstanding");
      return;
    end
    want = pending_results.pop_front();
    if (got.status != want.status || got.request != want.request ||
        got.qlen != want.qlen || got.sidx != want.sidx || got.slen != want.slen) begin
      fail($sformatf({"mismatch: expected status %0d word %h len %0d shortest %0d/%0d,",
                      " got status %0d word %h len %0d shortest %0d/%0d"},
                     want.status, want.request, want.qlen, want.sidx, want.slen,
                     got.status, got.request, got.qlen, got.sidx, got.slen));
    end
  endfunction
endclass

module testbench;
  import mqsd_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                in_req_type = 1'b0;
  logic [QSEL_W-1:0]   in_queue_index = '0;
  logic [REQ_W-1:0]    in_request_word = '0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [ACTCFG_W-1:0] cfg_active_queues = '0;
  logic                out_valid;
  logic [1:0]          out_status;
  logic [REQ_W-1:0]    out_request;
  logic [LEN_W-1:0]    out_queue_length;
  logic [QSEL_W-1:0]   out_shortest_index;
  logic [LEN_W-1:0]    out_shortest_length;

  queue_bank_model bank;
  int unsigned     burst_left = 0;

  multi_queue_shortest_dispatch #(
    .NUM_QUEUES (BANK_QUEUES),
    .QUEUE_DEPTH(BANK_DEPTH)
  ) dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_req_type        (in_req_type),
    .in_queue_index     (in_queue_index),
    .in_request_word    (in_request_word),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_active_queues  (cfg_active_queues),
    .out_valid          (out_valid),
    .out_status         (out_status),
    .out_request        (out_request),
    .out_queue_length   (out_queue_length),
    .out_shortest_index (out_shortest_index),
    .out_shortest_length(out_shortest_length)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Check every strobed result against the oldest expectation
  always @(posedge clk) begin : result_monitor
    dispatch_result_t got;
    if (rst_n && out_valid) begin
      got.status  = status_t'(out_status);
      got.request = out_request;
      got.qlen    = out_queue_length;
      got.sidx    = out_shortest_index;
      got.slen    = out_shortest_length;
      bank.check_result(got);
    end
  end

  // Hold the command until the block takes it; return at the next falling edge
  task automatic send_item(op_t op, logic [2:0] q, logic [63:0] word);
    start           <= 1'b1;
    in_req_type     <= op;
    in_queue_index  <= q;
    in_request_word <= word;
    do @(posedge clk); while (busy !== 1'b0);
    bank.note_command(op, q, word);
    @(negedge clk);
  endtask

  // Send in bursts, dropping start for a random gap between them
  task automatic send_paced(op_t op, logic [2:0] q, logic [63:0] word);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? 80 : $urandom_range(1, 16);
    end
    send_item(op, q, word);
    burst_left--;
  endtask

  // Idle the command side until every result has come back
  task automatic drain();
    start <= 1'b0;
    burst_left = 0;
    while (bank.pending_results.size() != 0) @(posedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_active(logic [3:0] value);
    cfg_valid         <= 1'b1;
    cfg_active_queues <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    bank.set_active(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic biased towards enqueue or dequeue by enq_pct
  task automatic run_phase(int unsigned n_items, int unsigned enq_pct);
    op_t         op;
    logic [2:0]  q;
    logic [63:0] word;
    repeat (n_items) begin
      op = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      if ($urandom_range(0, 9) == 0) q = $urandom_range(0, 7);
      else q = $urandom_range(0, bank.in_use() - 1);
      case ($urandom_range(0, 9))
        0:       word = '1;
        1:       word = '0;
        default: word = {$urandom, $urandom};
      endcase
      send_paced(op, q, word);
    end
  endtask

  initial begin : stimulus
    int unsigned cfg_vals [12] = '{1, 8, 2, 0, 15, 4, 9, 3, 8, 1, 5, 8};
    int unsigned enq_bias [3]  = '{85, 20, 55};
    bank = new();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty dequeue, extreme words, changes of the reported shortest queue
    write_active(4'd8);
    send_paced(OP_DEQ, 3'd0, 64'h0);
    send_paced(OP_ENQ, 3'd7, 64'hFFFF_FFFF_FFFF_FFFF);
    send_paced(OP_ENQ, 3'd0, 64'h0);
    send_paced(OP_ENQ, 3'd3, 64'hA5A5_5A5A_C3C3_3C3C);
    send_paced(OP_DEQ, 3'd7, 64'h1234);
    send_paced(OP_DEQ, 3'd7, 64'h0);
    send_paced(OP_ENQ, 3'd5, 64'h8000_0000_0000_0001);
    drain();

    // Zero active behaves as one: everything above queue zero is inactive
    write_active(4'd0);
    send_paced(OP_ENQ, 3'd1, 64'h5555_5555_5555_5555);
    send_paced(OP_DEQ, 3'd7, 64'h0);
    send_paced(OP_DEQ, 3'd0, 64'h0);
    send_paced(OP_ENQ, 3'd0, 64'h0123_4567_89AB_CDEF);
    drain();

    // Setting above the bank size behaves as the full bank
    write_active(4'd15);
    send_paced(OP_ENQ, 3'd7, 64'hDEAD_BEEF_0000_0001);
    send_paced(OP_DEQ, 3'd3, 64'h0);
    send_paced(OP_DEQ, 3'd5, 64'h0);
    drain();

    // Random phases over several settings, alternating fill and drain pressure
    cfg_vals[5] = $urandom_range(2, 7);
    foreach (cfg_vals[p]) begin
      write_active(cfg_vals[p][3:0]);
      run_phase(58, enq_bias[p % 3]);
      drain();
    end

    repeat (10) @(posedge clk);
    if (bank.failures == 0 && bank.pending_results.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
